@@ rtl/core/pfc_pkg.sv @@
// ============================================================================
// pfc_pkg
// Types, format codes and helpers for the pixel format converter.
// ============================================================================
`default_nettype none

package pfc_pkg;

    localparam int unsigned FMT_W  = 3;
    localparam int unsigned BYTE_W = 8;

    localparam logic [FMT_W-1:0] FMT_RGB  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_BGR  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGBA = 3'd2;
    localparam logic [FMT_W-1:0] FMT_BGRA = 3'd3;
    localparam logic [FMT_W-1:0] FMT_GRAY = 3'd4;
    localparam logic [FMT_W-1:0] FMT_NV12 = 3'd5;

    localparam logic CFG_SOURCE_FORMAT = 1'b0;
    localparam logic CFG_TARGET_FORMAT = 1'b1;

    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_byte in_byte0;
        t_byte in_byte1;
        t_byte in_byte2;
        t_byte in_byte3;
        t_byte chroma_u;
        t_byte chroma_v;
    } t_pix_in;

    typedef struct packed {
        t_byte out_byte0;
        t_byte out_byte1;
        t_byte out_byte2;
        t_byte out_byte3;
        logic  status;
    } t_pix_out;

    typedef struct packed {
        t_byte r;
        t_byte g;
        t_byte b;
    } t_rgb;

    // Clamp a signed sum to 0..255.
    function automatic t_byte sat_byte(input logic signed [10:0] v);
        t_byte res;
        if (v < 11'sd0) begin
            res = 8'd0;
        end else if (v > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // Bytes per pixel for the color formats (gray and nv12 copy one byte).
    function automatic logic [2:0] copy_bytes(input logic [FMT_W-1:0] fmt);
        logic [2:0] n;
        case (fmt)
            FMT_RGB, FMT_BGR:   n = 3'd3;
            FMT_RGBA, FMT_BGRA: n = 3'd4;
            default:            n = 3'd1;
        endcase
        return n;
    endfunction

    // Red sits at byte 2 for the bgr orders, at byte 0 otherwise.
    function automatic logic red_high(input logic [FMT_W-1:0] fmt);
        return (fmt == FMT_BGR) || (fmt == FMT_BGRA);
    endfunction

    function automatic logic has_alpha(input logic [FMT_W-1:0] fmt);
        return (fmt == FMT_RGBA) || (fmt == FMT_BGRA);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pfc_yuv2rgb.sv @@
// ============================================================================
// pfc_yuv2rgb
// Fixed-point NV12 (BT.601) to RGB, floor shift by 10, clamped to 0..255.
// ============================================================================
`default_nettype none

module pfc_yuv2rgb (
    input  wire pfc_pkg::t_byte i_y,
    input  wire pfc_pkg::t_byte i_u,
    input  wire pfc_pkg::t_byte i_v,
    output pfc_pkg::t_rgb       o_rgb
);

    logic signed [8:0]  u_s;
    logic signed [8:0]  v_s;
    logic signed [19:0] prod_r;
    logic signed [19:0] prod_g;
    logic signed [19:0] prod_b;
    logic signed [10:0] d_r;
    logic signed [10:0] d_g;
    logic signed [10:0] d_b;
    logic signed [10:0] y_s;

    assign u_s = $signed({1'b0, i_u}) - 9'sd128;
    assign v_s = $signed({1'b0, i_v}) - 9'sd128;

    assign prod_r = 20'(v_s) * 20'sd1436;
    assign prod_g = 20'(u_s) * 20'sd352 + 20'(v_s) * 20'sd731;
    assign prod_b = 20'(u_s) * 20'sd1815;

    // arithmetic shift gives the floor
    assign d_r = 11'(prod_r >>> 10);
    assign d_g = 11'(prod_g >>> 10);
    assign d_b = 11'(prod_b >>> 10);

    assign y_s = $signed({3'b000, i_y});

    assign o_rgb.r = pfc_pkg::sat_byte(y_s + d_r);
    assign o_rgb.g = pfc_pkg::sat_byte(y_s - d_g);
    assign o_rgb.b = pfc_pkg::sat_byte(y_s + d_b);

endmodule

`default_nettype wire

@@ rtl/core/pfc_convert.sv @@
// ============================================================================
// pfc_convert
// Per-pixel conversion selected by source and target format codes.
// ============================================================================
`default_nettype none

module pfc_convert (
    input  wire logic [pfc_pkg::FMT_W-1:0] i_src_fmt,
    input  wire logic [pfc_pkg::FMT_W-1:0] i_tgt_fmt,
    input  wire pfc_pkg::t_pix_in          i_pix,
    output pfc_pkg::t_pix_out              o_pix
);

    pfc_pkg::t_rgb  yuv_rgb;
    pfc_pkg::t_byte src [4];
    pfc_pkg::t_byte dst [4];
    pfc_pkg::t_byte c_r;
    pfc_pkg::t_byte c_g;
    pfc_pkg::t_byte c_b;
    pfc_pkg::t_byte c_a;
    pfc_pkg::t_byte l_r;
    pfc_pkg::t_byte l_b;
    logic [15:0]    luma_sum;
    logic [2:0]     n_copy;
    logic           status;

    pfc_yuv2rgb u_yuv2rgb (
        .i_y   (i_pix.in_byte0),
        .i_u   (i_pix.chroma_u),
        .i_v   (i_pix.chroma_v),
        .o_rgb (yuv_rgb)
    );

    assign src[0] = i_pix.in_byte0;
    assign src[1] = i_pix.in_byte1;
    assign src[2] = i_pix.in_byte2;
    assign src[3] = i_pix.in_byte3;

    // channels of a color source in r, g, b, a order
    always_comb begin
        c_g = src[1];
        if (pfc_pkg::red_high(i_src_fmt)) begin
            c_r = src[2];
            c_b = src[0];
        end else begin
            c_r = src[0];
            c_b = src[2];
        end
        c_a = pfc_pkg::has_alpha(i_src_fmt) ? src[3] : 8'd255;
        if (i_src_fmt == pfc_pkg::FMT_GRAY) begin
            c_r = src[0];
            c_g = src[0];
            c_b = src[0];
        end else if (i_src_fmt == pfc_pkg::FMT_NV12) begin
            c_r = yuv_rgb.r;
            c_g = yuv_rgb.g;
            c_b = yuv_rgb.b;
        end
    end

    // luma taps the source bytes directly, never the yuv path
    assign l_r = pfc_pkg::red_high(i_src_fmt) ? src[2] : src[0];
    assign l_b = pfc_pkg::red_high(i_src_fmt) ? src[0] : src[2];

    assign luma_sum = 16'd77 * 16'(l_r) + 16'd150 * 16'(src[1]) + 16'd29 * 16'(l_b)
                    + 16'd128;
    assign n_copy   = pfc_pkg::copy_bytes(i_src_fmt);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dst[i] = 8'd0;
        end
        status = pfc_pkg::STATUS_OK;
        if (i_src_fmt > pfc_pkg::FMT_NV12 || i_tgt_fmt > pfc_pkg::FMT_NV12) begin
            status = pfc_pkg::STATUS_UNSUPPORTED;
        end else if (i_src_fmt == i_tgt_fmt) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < n_copy) begin
                    dst[i] = src[i];
                end
            end
        end else if (i_tgt_fmt == pfc_pkg::FMT_NV12) begin
            status = pfc_pkg::STATUS_UNSUPPORTED;
        end else if (i_tgt_fmt == pfc_pkg::FMT_GRAY) begin
            dst[0] = (i_src_fmt == pfc_pkg::FMT_NV12) ? src[0] : luma_sum[15:8];
        end else begin
            dst[1] = c_g;
            if (pfc_pkg::red_high(i_tgt_fmt)) begin
                dst[0] = c_b;
                dst[2] = c_r;
            end else begin
                dst[0] = c_r;
                dst[2] = c_b;
            end
            if (pfc_pkg::has_alpha(i_tgt_fmt)) begin
                dst[3] = c_a;
            end
        end
    end

    assign o_pix.out_byte0 = dst[0];
    assign o_pix.out_byte1 = dst[1];
    assign o_pix.out_byte2 = dst[2];
    assign o_pix.out_byte3 = dst[3];
    assign o_pix.status    = status;

endmodule

`default_nettype wire

@@ rtl/core/pixel_format_converter_top.sv @@
// ============================================================================
// pixel_format_converter_top
// Pixel format converter: input register, conversion logic, result register.
// ============================================================================
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_pix_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_pix_out)
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  One beat per clock while the output is taken; input then result register.
//  The rate is set by the single conversion stage between the two registers.
//  Reset clears the valid flags and both format registers to rgb.
//  A stalled result holds in the output register; the input register still
//  fills, and both stages drain together once the output is taken.
// ============================================================================
`default_nettype none

module pixel_format_converter_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [pfc_pkg::FMT_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire pfc_pkg::t_pix_in              i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output pfc_pkg::t_pix_out                  o_out_data
);

    logic [pfc_pkg::FMT_W-1:0] r_src_fmt;
    logic [pfc_pkg::FMT_W-1:0] r_tgt_fmt;
    logic                      r_in_valid;
    pfc_pkg::t_pix_in          r_in_data;
    logic                      r_out_valid;
    pfc_pkg::t_pix_out         r_out_data;
    logic                      n_in_valid;
    logic                      n_out_valid;
    pfc_pkg::t_pix_out         conv_pix;
    logic                      out_free;
    logic                      advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    assign n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !out_free);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt   <= pfc_pkg::FMT_RGB;
            r_tgt_fmt   <= pfc_pkg::FMT_RGB;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pfc_pkg::CFG_SOURCE_FORMAT: r_src_fmt <= i_cfg_data;
                    pfc_pkg::CFG_TARGET_FORMAT: r_tgt_fmt <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= conv_pix;
        end
    end

    pfc_convert u_convert (
        .i_src_fmt (r_src_fmt),
        .i_tgt_fmt (r_tgt_fmt),
        .i_pix     (r_in_data),
        .o_pix     (conv_pix)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    a_unsupported_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.status |->
            (r_out_data.out_byte0 == 8'd0) && (r_out_data.out_byte1 == 8'd0) &&
            (r_out_data.out_byte2 == 8'd0) && (r_out_data.out_byte3 == 8'd0))
        else $error("unsupported result carries nonzero bytes");

    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stage empty but not ready");

    a_out_from_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result beat without a pending input");

    a_stage_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_in_data))
        else $error("input stage lost a beat while blocked");
`endif

endmodule

`default_nettype wire

@@ verif/tb_pixel_format_converter_top.sv @@
// ============================================================================
// tb_pixel_format_converter_top
// Self-checking bench for the pixel format converter. A driver pops pixels
// from a pending queue onto the input channel, and a monitor takes result
// beats with random stalls. Each accepted pixel is converted in the bench
// under the format pair in force at the time. The monitor checks the result
// beats against those converted pixels in order. Format changes happen
// only after the pipe has drained. A short directed pass is followed by
// random pixels under every source/target pair, the undefined codes included.
// ============================================================================
`default_nettype none

module tb_pixel_format_converter_top;
    import pfc_pkg::*;

    localparam logic [FMT_W-1:0] FMT_UNDEF6 = 3'd6;
    localparam logic [FMT_W-1:0] FMT_UNDEF7 = 3'd7;
    localparam int unsigned RAND_PER_PAIR = 17;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic             i_cfg_idx   = CFG_SOURCE_FORMAT;
    logic [FMT_W-1:0] i_cfg_data  = FMT_RGB;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_pix_in          i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_pix_out         o_out_data;

    logic [FMT_W-1:0] src_fmt = FMT_RGB;
    logic [FMT_W-1:0] tgt_fmt = FMT_RGB;

    t_pix_in  pending_pixels [$];
    t_pix_out expected_pixels [$];
    t_pix_out want;
    int       queued_count   = 0;
    int       accepted_count = 0;
    int       errors         = 0;
    int       in_gap         = 0;
    int       out_stall      = 0;
    bit       in_calm        = 1'b0;
    bit       out_calm       = 1'b0;

    pixel_format_converter_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Conversion predictor
    // ------------------------------------------------------------------------
    function automatic int red_pos(logic [FMT_W-1:0] fmt);
        return (fmt == FMT_BGR || fmt == FMT_BGRA) ? 2 : 0;
    endfunction

    function automatic bit carries_alpha(logic [FMT_W-1:0] fmt);
        return fmt == FMT_RGBA || fmt == FMT_BGRA;
    endfunction

    function automatic t_byte clamp_byte(int v);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return t_byte'(v);
    endfunction

    function automatic t_pix_out convert_pixel(logic [FMT_W-1:0] sf, logic [FMT_W-1:0] tf,
                                               t_pix_in px);
        t_byte    src [4];
        t_byte    dst [4];
        t_byte    r, g, b, a;
        t_pix_out res;
        int       n, i, sum, y, u, v;
        src[0] = px.in_byte0;
        src[1] = px.in_byte1;
        src[2] = px.in_byte2;
        src[3] = px.in_byte3;
        for (i = 0; i < 4; i++) begin
            dst[i] = 8'd0;
        end
        res.status = STATUS_OK;
        if (sf > FMT_NV12 || tf > FMT_NV12) begin
            res.status = STATUS_UNSUPPORTED;
        end else if (sf == tf) begin
            n = (sf == FMT_GRAY || sf == FMT_NV12) ? 1 : (carries_alpha(sf) ? 4 : 3);
            for (i = 0; i < n; i++) begin
                dst[i] = src[i];
            end
        end else if (tf == FMT_NV12) begin
            res.status = STATUS_UNSUPPORTED;
        end else if (tf == FMT_GRAY) begin
            if (sf == FMT_NV12) begin
                dst[0] = src[0];
            end else begin
                sum = 77 * src[red_pos(sf)] + 150 * src[1] + 29 * src[2 - red_pos(sf)] + 128;
                dst[0] = t_byte'(sum >> 8);
            end
        end else begin
            a = 8'd255;
            if (sf == FMT_GRAY) begin
                r = src[0];
                g = src[0];
                b = src[0];
            end else if (sf == FMT_NV12) begin
                y = int'(px.in_byte0);
                u = int'(px.chroma_u) - 128;
                v = int'(px.chroma_v) - 128;
                // arithmetic shifts floor toward minus infinity
                r = clamp_byte(y + ((1436 * v) >>> 10));
                g = clamp_byte(y - ((352 * u + 731 * v) >>> 10));
                b = clamp_byte(y + ((1815 * u) >>> 10));
            end else begin
                r = src[red_pos(sf)];
                g = src[1];
                b = src[2 - red_pos(sf)];
                if (carries_alpha(sf)) begin
                    a = src[3];
                end
            end
            dst[red_pos(tf)]     = r;
            dst[1]               = g;
            dst[2 - red_pos(tf)] = b;
            if (carries_alpha(tf)) begin
                dst[3] = a;
            end
        end
        res.out_byte0 = dst[0];
        res.out_byte1 = dst[1];
        res.out_byte2 = dst[2];
        res.out_byte3 = dst[3];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int gap_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_byte rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'd0;
        end
        if (r == 1) begin
            return 8'd255;
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic t_pix_in make_pixel(t_byte b0, t_byte b1, t_byte b2, t_byte b3,
                                           t_byte cu, t_byte cv);
        t_pix_in px;
        px.in_byte0 = b0;
        px.in_byte1 = b1;
        px.in_byte2 = b2;
        px.in_byte3 = b3;
        px.chroma_u = cu;
        px.chroma_v = cv;
        return px;
    endfunction

    task automatic queue_pixel(t_pix_in px);
        pending_pixels.push_back(px);
        queued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic idx, logic [FMT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SOURCE_FORMAT) begin
            src_fmt = val;
        end else begin
            tgt_fmt = val;
        end
    endtask

    task automatic set_formats(logic [FMT_W-1:0] sf, logic [FMT_W-1:0] tf);
        wait_drained();
        repeat (3) @(posedge i_clk);
        write_reg(CFG_SOURCE_FORMAT, sf);
        write_reg(CFG_TARGET_FORMAT, tf);
    endtask

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_pixels.push_back(convert_pixel(src_fmt, tgt_fmt, i_in_data));
                accepted_count++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_pixels.pop_front();
                    if ($urandom_range(0, 49) == 0) begin
                        in_calm = !in_calm;
                    end
                    in_gap = gap_len(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result beat with no pixel pending: %h", o_out_data);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_out_data.out_byte0 !== want.out_byte0) begin
                        $error("out_byte0: expected %0d, got %0d",
                               want.out_byte0, o_out_data.out_byte0);
                        errors++;
                    end
                    if (o_out_data.out_byte1 !== want.out_byte1) begin
                        $error("out_byte1: expected %0d, got %0d",
                               want.out_byte1, o_out_data.out_byte1);
                        errors++;
                    end
                    if (o_out_data.out_byte2 !== want.out_byte2) begin
                        $error("out_byte2: expected %0d, got %0d",
                               want.out_byte2, o_out_data.out_byte2);
                        errors++;
                    end
                    if (o_out_data.out_byte3 !== want.out_byte3) begin
                        $error("out_byte3: expected %0d, got %0d",
                               want.out_byte3, o_out_data.out_byte3);
                        errors++;
                    end
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 59) == 0) begin
                out_calm = !out_calm;
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                out_stall = ($urandom_range(0, 5) == 0) ? gap_len(out_calm) : 0;
                i_out_ready <= (out_stall == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [5:0] pairs [64];
        logic [5:0] swap;
        int         k, j;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset formats: rgb copy
        queue_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        queue_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

        // luma extremes and channel order
        set_formats(FMT_RGBA, FMT_GRAY);
        queue_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0));
        queue_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        set_formats(FMT_BGR, FMT_GRAY);
        queue_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd7, 8'd0, 8'd0));
        set_formats(FMT_NV12, FMT_GRAY);
        queue_pixel(make_pixel(8'd200, 8'd1, 8'd2, 8'd3, 8'd9, 8'd250));

        // expansion, reorder, alpha fill and alpha copy
        set_formats(FMT_GRAY, FMT_BGRA);
        queue_pixel(make_pixel(8'd77, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5));
        set_formats(FMT_RGBA, FMT_BGR);
        queue_pixel(make_pixel(8'd10, 8'd20, 8'd30, 8'd40, 8'd0, 8'd0));
        set_formats(FMT_BGR, FMT_RGBA);
        queue_pixel(make_pixel(8'd10, 8'd20, 8'd30, 8'd40, 8'd0, 8'd0));
        set_formats(FMT_BGRA, FMT_RGBA);
        queue_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6));

        // yuv: clamp high, clamp low, neutral chroma, floor on negatives
        set_formats(FMT_NV12, FMT_RGB);
        queue_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255));
        queue_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        queue_pixel(make_pixel(8'd128, 8'd9, 8'd9, 8'd9, 8'd128, 8'd128));
        queue_pixel(make_pixel(8'd16, 8'd0, 8'd0, 8'd0, 8'd127, 8'd129));

        // nv12 copy, unsupported target, undefined codes
        set_formats(FMT_NV12, FMT_NV12);
        queue_pixel(make_pixel(8'd99, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5));
        set_formats(FMT_RGB, FMT_NV12);
        queue_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6));
        set_formats(FMT_UNDEF6, FMT_UNDEF6);
        queue_pixel(make_pixel(8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66));
        set_formats(FMT_RGB, FMT_UNDEF7);
        queue_pixel(make_pixel(8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66));
        set_formats(FMT_UNDEF7, FMT_NV12);
        queue_pixel(make_pixel(8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66));

        // plain copies
        set_formats(FMT_GRAY, FMT_GRAY);
        queue_pixel(make_pixel(8'd33, 8'd44, 8'd55, 8'd66, 8'd77, 8'd88));
        set_formats(FMT_RGBA, FMT_RGBA);
        queue_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6));

        // random pixels under every format pair, shuffled
        for (k = 0; k < 64; k++) begin
            pairs[k] = k[5:0];
        end
        for (k = 63; k > 0; k--) begin
            j        = $urandom_range(0, k);
            swap     = pairs[k];
            pairs[k] = pairs[j];
            pairs[j] = swap;
        end
        for (k = 0; k < 64; k++) begin
            set_formats(pairs[k][5:3], pairs[k][2:0]);
            repeat (RAND_PER_PAIR) begin
                queue_pixel(make_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                                       rand_byte(), rand_byte()));
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ pixel_format_converter_top.f @@
rtl/core/pfc_pkg.sv
rtl/core/pfc_yuv2rgb.sv
rtl/core/pfc_convert.sv
rtl/core/pixel_format_converter_top.sv
verif/tb_pixel_format_converter_top.sv
